// ===== design/rma_pkg.sv =====
// shared types and constants for the raw moment accumulator
// used by rma_ctrl, rma_dp and raw_moment_accumulator; no dependencies
package rma_pkg;

  // sample format, signed q1.15
  localparam int SAMPLE_W = 16;
  localparam int FRAC_W   = 15;
  // a power of the sample keeps one extra bit so that +1.0 is exact
  localparam int POWER_W  = SAMPLE_W + 1;
  // quotient bits produced by the divider, enough for a magnitude of 1.0
  localparam int QUOT_W   = 16;
  localparam int QCNT_W   = $clog2(QUOT_W);

  localparam int ORDER_W  = 3;

  // configuration registers
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 7;
  localparam int NSTR_W      = 7;
  localparam int NMOM_W      = 3;
  localparam logic [CFG_INDEX_W-1:0] CFG_NUM_STREAMS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_NUM_MOMENTS = 2'd1;
  localparam logic [NSTR_W-1:0] NUM_STREAMS_RST = 7'd3;
  localparam logic [NMOM_W-1:0] NUM_MOMENTS_RST = 3'd4;
  localparam int NUM_STREAMS_MIN = 3;

  // parameter defaults
  localparam int MAX_MOMENTS_DEF = 4;
  localparam int MAX_STREAMS_DEF = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_DLOAD,
    ST_DIV,
    ST_OUT
  } rma_state_t;

  typedef struct packed {
    logic acc_load;
    logic acc_step;
    logic div_load;
    logic div_step;
    logic out_load;
    logic out_last;
    logic sum_clear;
  } rma_cmd_t;

  typedef struct packed {
    logic out_free;
  } rma_sts_t;

endpackage

// ===== design/rma_ctrl.sv =====
// sequencer for the raw moment accumulator: accumulate, divide, emit
// depends on rma_pkg; drives the commands of rma_dp
module rma_ctrl #(
  parameter int MAX_MOMENTS = rma_pkg::MAX_MOMENTS_DEF,
  parameter int MAX_STREAMS = rma_pkg::MAX_STREAMS_DEF,
  localparam int IW = (MAX_MOMENTS > 1) ? $clog2(MAX_MOMENTS) : 1,
  localparam int MW = $clog2(MAX_MOMENTS + 1),
  localparam int NW = $clog2(MAX_STREAMS + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [NW-1:0]     n_eff,
  input  logic [MW-1:0]     m_eff,
  input  rma_pkg::rma_sts_t sts,
  output rma_pkg::rma_cmd_t cmd,
  output logic [IW-1:0]     idx
);

  localparam int CW = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
  localparam int LW = ((IW + 1) > MW) ? (IW + 1) : MW;

  rma_pkg::rma_state_t state, state_next;
  logic [IW-1:0] idx_next;
  logic [rma_pkg::QCNT_W-1:0] bitcnt, bitcnt_next;
  logic [CW-1:0] count, count_next;

  logic [NW-1:0] count_inc;
  logic [LW-1:0] idx_inc;
  logic          run_last;
  logic          acc_done;

  assign count_inc = NW'(count) + NW'(1);
  assign idx_inc   = LW'(idx) + LW'(1);
  assign run_last  = (idx_inc == LW'(m_eff));
  assign acc_done  = (idx == IW'(MAX_MOMENTS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= rma_pkg::ST_IDLE;
      idx    <= '0;
      bitcnt <= '0;
      count  <= '0;
    end else begin
      state  <= state_next;
      idx    <= idx_next;
      bitcnt <= bitcnt_next;
      count  <= count_next;
    end
  end

  always_comb begin
    state_next  = state;
    idx_next    = idx;
    bitcnt_next = bitcnt;
    count_next  = count;
    cmd         = '0;
    s_tready    = 1'b0;
    case (state)
      rma_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.acc_load = 1'b1;
          idx_next     = '0;
          state_next   = rma_pkg::ST_ACC;
        end
      end
      rma_pkg::ST_ACC: begin
        cmd.acc_step = 1'b1;
        if (acc_done) begin
          idx_next = '0;
          if (count_inc >= n_eff) begin
            count_next = '0;
            state_next = rma_pkg::ST_DLOAD;
          end else begin
            count_next = CW'(count_inc);
            state_next = rma_pkg::ST_IDLE;
          end
        end else begin
          idx_next = idx + IW'(1);
        end
      end
      rma_pkg::ST_DLOAD: begin
        cmd.div_load = 1'b1;
        bitcnt_next  = '0;
        state_next   = rma_pkg::ST_DIV;
      end
      rma_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        bitcnt_next  = bitcnt + rma_pkg::QCNT_W'(1);
        if (bitcnt == rma_pkg::QCNT_W'(rma_pkg::QUOT_W - 1)) begin
          state_next = rma_pkg::ST_OUT;
        end
      end
      rma_pkg::ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = run_last;
          if (run_last) begin
            cmd.sum_clear = 1'b1;
            idx_next      = '0;
            state_next    = rma_pkg::ST_IDLE;
          end else begin
            idx_next   = idx + IW'(1);
            state_next = rma_pkg::ST_DLOAD;
          end
        end
      end
      default: begin
        state_next = rma_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  // a result is never written over one that has not been taken
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("result register loaded while occupied");

  // the last result of a run returns the block to accepting samples
  a_run_end: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && cmd.out_last) |=> (state == rma_pkg::ST_IDLE && s_tready))
    else $error("run did not end after last result");

  // accumulation of a sample always starts with the first power
  a_acc_start: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == rma_pkg::ST_ACC && idx == '0))
    else $error("accumulation did not start at first power");
`endif

endmodule

// ===== design/rma_dp.sv =====
// datapath: shared power multiplier, power sums, bit-serial divider, result register
// depends on rma_pkg; controlled by rma_ctrl
module rma_dp #(
  parameter int MAX_MOMENTS = rma_pkg::MAX_MOMENTS_DEF,
  parameter int MAX_STREAMS = rma_pkg::MAX_STREAMS_DEF,
  localparam int IW = (MAX_MOMENTS > 1) ? $clog2(MAX_MOMENTS) : 1,
  localparam int NW = $clog2(MAX_STREAMS + 1)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  rma_pkg::rma_cmd_t                   cmd,
  output rma_pkg::rma_sts_t                   sts,
  input  logic [IW-1:0]                       idx,
  input  logic [NW-1:0]                       n_eff,
  input  logic signed [rma_pkg::SAMPLE_W-1:0] sample,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [rma_pkg::SAMPLE_W-1:0]        m_tdata,
  output logic [rma_pkg::ORDER_W-1:0]         m_tuser,
  output logic                                m_tlast
);

  localparam int SW   = rma_pkg::SAMPLE_W;
  localparam int PW   = rma_pkg::POWER_W;
  localparam int QW   = rma_pkg::QUOT_W;
  localparam int FW   = rma_pkg::FRAC_W;
  localparam int PRW  = PW + SW;
  localparam int SUMW = ((MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1) + PW;
  localparam int DSW  = NW + QW - 1;
  localparam int DW   = (SUMW > DSW) ? SUMW : DSW;

  logic signed [SW-1:0]   smp;
  logic signed [PW-1:0]   pwr;
  logic signed [SUMW-1:0] sums [MAX_MOMENTS];
  logic [DW-1:0]          mag;
  logic [DW-1:0]          dsr;
  logic [QW-1:0]          quot;
  logic                   neg;

  logic signed [PRW-1:0]  prod;
  logic signed [PRW-1:0]  prod_adj;
  logic signed [PW-1:0]   pwr_next;
  logic signed [SUMW-1:0] sum_sel;
  logic                   ge;
  logic [QW:0]            quot_neg;
  logic [SW-1:0]          avg;

  // q1.15 product truncated toward zero
  assign prod     = PRW'(pwr) * PRW'(smp);
  assign prod_adj = prod + (prod[PRW-1] ? PRW'((1 << FW) - 1) : PRW'(0));
  assign pwr_next = prod_adj[FW+PW-1:FW];

  assign sum_sel  = sums[idx];
  assign ge       = (mag >= dsr);

  // signed average from magnitude quotient, saturated to q1.15 on both sides
  assign quot_neg = -{1'b0, quot};
  always_comb begin
    if (neg && quot[QW-1]) begin
      avg = {1'b1, {(SW-1){1'b0}}};
    end else if (neg) begin
      avg = quot_neg[SW-1:0];
    end else if (quot[QW-1]) begin
      avg = {1'b0, {(SW-1){1'b1}}};
    end else begin
      avg = SW'(quot);
    end
  end

  assign sts.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (cmd.acc_load) begin
      smp <= sample;
      pwr <= PW'(sample);
    end else if (cmd.acc_step) begin
      pwr <= pwr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.sum_clear) begin
      for (int i = 0; i < MAX_MOMENTS; i++) begin
        sums[i] <= '0;
      end
    end else if (cmd.acc_step) begin
      sums[idx] <= sums[idx] + SUMW'(pwr);
    end
  end

  // restoring division of |sum| by the stream count, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      neg  <= sum_sel[SUMW-1];
      mag  <= DW'(sum_sel[SUMW-1] ? -sum_sel : sum_sel);
      dsr  <= DW'({n_eff, {(QW-1){1'b0}}});
      quot <= '0;
    end else if (cmd.div_step) begin
      if (ge) begin
        mag <= mag - dsr;
      end
      quot <= {quot[QW-2:0], ge};
      dsr  <= dsr >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= avg;
      m_tuser <= rma_pkg::ORDER_W'({1'b0, idx} + (IW + 1)'(1));
      m_tlast <= cmd.out_last;
    end
  end

endmodule

// ===== design/raw_moment_accumulator.sv =====
// top level of the raw moment accumulator: config registers, sequencer and datapath
// depends on rma_pkg, rma_ctrl and rma_dp
//
// Takes one signed q1.15 sample per transaction, one from each input stream in turn
// for the same position. Every sample and its successive powers (p1 = x,
// p(k+1) = p(k)*x truncated toward zero in q1.15, +1.0 kept exact) are added into
// MAX_MOMENTS running sums, one power per cycle through a single shared multiplier,
// so the input is held off until a sample's last power is added. Once num_streams
// samples are in, one result per configured moment goes out in increasing order:
// the sum divided by the stream count, truncated toward zero and saturated to q1.15,
// with tlast on the highest moment. The division is a restoring divider giving one
// quotient bit a cycle, so each result needs a load, one step per quotient bit and
// a hand-off to the output register, plus any output back-pressure; the input is
// held off during that phase and the sums are cleared with the last result. Settings
// out of range clamp: num_streams to 3..MAX_STREAMS, num_moments to 1..MAX_MOMENTS.
// Write registers only while the block is idle; the block does not enforce it.
module raw_moment_accumulator #(
  parameter int MAX_MOMENTS = rma_pkg::MAX_MOMENTS_DEF,
  parameter int MAX_STREAMS = rma_pkg::MAX_STREAMS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // input samples
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [rma_pkg::SAMPLE_W-1:0]           s_tdata,   // [15:0] sample
  // results
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [rma_pkg::SAMPLE_W-1:0]           m_tdata,   // [15:0] moment_value
  output logic [rma_pkg::ORDER_W-1:0]            m_tuser,   // [2:0] moment_order
  output logic                                   m_tlast,   // last_of_run
  // register writes
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [rma_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [rma_pkg::CFG_DATA_W-1:0]         cfg_data
);

  localparam int IW  = (MAX_MOMENTS > 1) ? $clog2(MAX_MOMENTS) : 1;
  localparam int MW  = $clog2(MAX_MOMENTS + 1);
  localparam int NW  = $clog2(MAX_STREAMS + 1);
  localparam int NXW = (NW > rma_pkg::NSTR_W) ? NW : rma_pkg::NSTR_W;
  localparam int MXW = (MW > rma_pkg::NMOM_W) ? MW : rma_pkg::NMOM_W;

  logic [rma_pkg::NSTR_W-1:0] num_streams;
  logic [rma_pkg::NMOM_W-1:0] num_moments;
  logic [NXW-1:0]             ns_ext;
  logic [MXW-1:0]             nm_ext;
  logic [NW-1:0]              n_eff;
  logic [MW-1:0]              m_eff;

  rma_pkg::rma_cmd_t cmd;
  rma_pkg::rma_sts_t sts;
  logic [IW-1:0]     idx;

  // registers always take a write in the cycle it is offered
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_streams <= rma_pkg::NUM_STREAMS_RST;
      num_moments <= rma_pkg::NUM_MOMENTS_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == rma_pkg::CFG_NUM_STREAMS) begin
        num_streams <= cfg_data[rma_pkg::NSTR_W-1:0];
      end
      if (cfg_index == rma_pkg::CFG_NUM_MOMENTS) begin
        num_moments <= cfg_data[rma_pkg::NMOM_W-1:0];
      end
    end
  end

  // clamp settings to their usable ranges
  assign ns_ext = NXW'(num_streams);
  assign nm_ext = MXW'(num_moments);

  always_comb begin
    if (ns_ext < NXW'(rma_pkg::NUM_STREAMS_MIN)) begin
      n_eff = NW'(rma_pkg::NUM_STREAMS_MIN);
    end else if (ns_ext > NXW'(MAX_STREAMS)) begin
      n_eff = NW'(MAX_STREAMS);
    end else begin
      n_eff = NW'(ns_ext);
    end
  end

  always_comb begin
    if (nm_ext == '0) begin
      m_eff = MW'(1);
    end else if (nm_ext > MXW'(MAX_MOMENTS)) begin
      m_eff = MW'(MAX_MOMENTS);
    end else begin
      m_eff = MW'(nm_ext);
    end
  end

  // sequencer: one accumulate step per power, then divide and emit per moment
  rma_ctrl #(
    .MAX_MOMENTS (MAX_MOMENTS),
    .MAX_STREAMS (MAX_STREAMS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .n_eff    (n_eff),
    .m_eff    (m_eff),
    .sts      (sts),
    .cmd      (cmd),
    .idx      (idx)
  );

  // multiplier, sums, divider and the output register
  rma_dp #(
    .MAX_MOMENTS (MAX_MOMENTS),
    .MAX_STREAMS (MAX_STREAMS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .idx      (idx),
    .n_eff    (n_eff),
    .sample   (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// ===== bench/raw_moment_accumulator_test.sv =====
// testbench for the raw moment accumulator: a directed table, then random positions
// depends on rma_pkg and raw_moment_accumulator; every result is checked against
// a power-sum model kept inside this module or against a typed value in the table
module raw_moment_accumulator_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MOMENTS        = rma_pkg::MAX_MOMENTS_DEF;
  localparam int STREAMS        = rma_pkg::MAX_STREAMS_DEF;
  localparam int RESET_CYCLES   = 12;
  // long enough for a sample that ends no position to finish its power chain
  localparam int SETTLE_CYCLES  = 12;
  localparam int DRAIN_CYCLES   = 40;
  localparam int HOLD_CYCLES    = 300;
  // longest quiet stretch is the long hold-off; otherwise it is the division of one
  // result plus a random output stall
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES         = 4;
  localparam int REPORT_LIMIT   = 10;

  // register indexes that the block has no register behind
  localparam logic [rma_pkg::CFG_INDEX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [rma_pkg::CFG_INDEX_W-1:0] CFG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic [rma_pkg::ORDER_W-1:0]  order;
    logic [rma_pkg::SAMPLE_W-1:0] value;
    logic                         last;
  } moment_t;

  typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_t;

  // one row of the directed table; want[k] is the typed value of moment k+1
  typedef struct packed {
    row_kind_t                                 kind;
    logic [rma_pkg::CFG_INDEX_W-1:0]           idx;
    logic [rma_pkg::CFG_DATA_W-1:0]            val;
    logic [rma_pkg::SAMPLE_W-1:0]              x;
    logic                                      typed;
    logic [MOMENTS-1:0][rma_pkg::SAMPLE_W-1:0] want;
  } dir_row_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [rma_pkg::SAMPLE_W-1:0]    s_tdata = '0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [rma_pkg::SAMPLE_W-1:0]    m_tdata;
  logic [rma_pkg::ORDER_W-1:0]     m_tuser;
  logic                            m_tlast;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [rma_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [rma_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  raw_moment_accumulator dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // model state: register copies, exact power sums and samples taken this position
  logic [rma_pkg::NSTR_W-1:0] cfg_streams = rma_pkg::NUM_STREAMS_RST;
  logic [rma_pkg::NMOM_W-1:0] cfg_moments = rma_pkg::NUM_MOMENTS_RST;
  longint            power_sums[MOMENTS];
  int                taken = 0;
  moment_t           fresh_run[MOMENTS];

  // moments still owed by the block, oldest first
  moment_t moment_q[$];

  int  errors = 0;
  int  samples_sent = 0;
  int  results_seen = 0;
  int  writes_done = 0;
  bit  steady = 1'b0;   // no gaps and no stalls while set
  bit  hold_ask = 1'b0;

  dir_row_t dir_rows[$];

  function automatic void note_error(input string msg);
    errors++;
    if (errors <= REPORT_LIMIT) $display("%0t mismatch: %s", $time, msg);
  endfunction

  // adds one sample into the power sums; returns how many moments the position
  // emits (zero unless the sample closes it) and leaves them in fresh_run
  function automatic int absorb_sample(input logic [rma_pkg::SAMPLE_W-1:0] raw);
    longint x;
    longint p;
    longint n;
    longint avg;
    int     m;
    x = longint'($signed(raw));
    p = x;
    for (int k = 0; k < MOMENTS; k++) begin
      power_sums[k] += p;
      // q1.15 product, truncated toward zero; +1.0 stays exact
      p = (p * x) / 32768;
    end
    taken++;
    n = (cfg_streams < rma_pkg::NUM_STREAMS_MIN) ? rma_pkg::NUM_STREAMS_MIN :
        (cfg_streams > STREAMS) ? STREAMS : cfg_streams;
    if (taken < n) return 0;
    m = (cfg_moments < 1) ? 1 : (cfg_moments > MOMENTS) ? MOMENTS : cfg_moments;
    for (int k = 0; k < m; k++) begin
      avg = power_sums[k] / n;
      if (avg > 32767) avg = 32767;
      if (avg < -32768) avg = -32768;
      fresh_run[k].order = rma_pkg::ORDER_W'(k + 1);
      fresh_run[k].value = avg[rma_pkg::SAMPLE_W-1:0];
      fresh_run[k].last  = (k + 1 == m);
    end
    for (int k = 0; k < MOMENTS; k++) power_sums[k] = 0;
    taken = 0;
    return m;
  endfunction

  function automatic logic [rma_pkg::SAMPLE_W-1:0] draw_sample(input bit heavy);
    // heavy positions lean on -1.0 so the sums climb toward their limit
    if (heavy && $urandom_range(0, 3) != 0) return 16'h8000;
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(0, 40)) - 16'd20;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic dir_row_t config_row(input logic [rma_pkg::CFG_INDEX_W-1:0] idx,
                                          input logic [rma_pkg::CFG_DATA_W-1:0] val);
    return '{ROW_CFG, idx, val, '0, 1'b0, '0};
  endfunction

  function automatic dir_row_t sample_row(input logic [rma_pkg::SAMPLE_W-1:0] x);
    return '{ROW_SAMPLE, '0, '0, x, 1'b0, '0};
  endfunction

  function automatic dir_row_t typed_row(
      input logic [rma_pkg::SAMPLE_W-1:0] x,
      input logic [MOMENTS-1:0][rma_pkg::SAMPLE_W-1:0] want);
    return '{ROW_SAMPLE, '0, '0, x, 1'b1, want};
  endfunction

  // offers one sample after a random gap; valid stays high when the next one follows
  // with no gap; typed rows replace the modeled values by the ones in the table
  task automatic offer_sample(input logic [rma_pkg::SAMPLE_W-1:0] x, input logic typed,
                              input logic [MOMENTS-1:0][rma_pkg::SAMPLE_W-1:0] want);
    int      gap;
    int      count;
    moment_t r;
    gap = steady ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= x;
    do @(posedge clk); while (!s_tready);
    samples_sent++;
    count = absorb_sample(x);
    for (int k = 0; k < count; k++) begin
      r = fresh_run[k];
      if (typed) r.value = want[k];
      moment_q.push_back(r);
    end
  endtask

  // register writes happen only with the block idle: every owed result out, and
  // time for a sample that ends no position to finish its power chain
  task automatic write_register(input logic [rma_pkg::CFG_INDEX_W-1:0] idx,
                                input logic [rma_pkg::CFG_DATA_W-1:0] val);
    s_tvalid <= 1'b0;
    while (moment_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    writes_done++;
    if (idx == rma_pkg::CFG_NUM_STREAMS) cfg_streams = val[rma_pkg::NSTR_W-1:0];
    else if (idx == rma_pkg::CFG_NUM_MOMENTS) cfg_moments = val[rma_pkg::NMOM_W-1:0];
  endtask

  // result side: check each transaction, then draw a stall for the next one;
  // once asked, a single long hold-off lets the block back up into its input
  int  rx_stall = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  always @(posedge clk) begin : result_side
    moment_t want;
    logic    ready_next;
    if (m_tvalid && m_tready) begin
      results_seen++;
      if (moment_q.size() == 0) begin
        note_error($sformatf("result with nothing owed: order %0d value %0d last %0b",
                             m_tuser, $signed(m_tdata), m_tlast));
      end else begin
        want = moment_q.pop_front();
        if (want.order !== m_tuser || want.value !== m_tdata || want.last !== m_tlast)
          note_error($sformatf("order %0d/%0d value %0d/%0d last %0b/%0b (exp/got)",
                               want.order, m_tuser, $signed(want.value),
                               $signed(m_tdata), want.last, m_tlast));
      end
    end
    if (hold_left != 0) begin
      hold_left--;
      ready_next = 1'b0;
    end else if (hold_ask && !hold_done) begin
      hold_done  = 1'b1;
      hold_left  = HOLD_CYCLES;
      ready_next = 1'b0;
    end else if (m_tvalid && m_tready) begin
      rx_stall   = steady ? 0 : $urandom_range(0, 9);
      ready_next = (rx_stall == 0);
    end else if (rx_stall != 0) begin
      rx_stall--;
      ready_next = (rx_stall == 0);
    end else begin
      ready_next = 1'b1;
    end
    m_tready <= ready_next;
  end

  // watchdog: too long with no transaction on any channel ends the run
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d idle cycles, %0d results still owed",
               idle_cycles, moment_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus
    int nstr;
    int nmom;
    int positions;
    int per;
    for (int k = 0; k < MOMENTS; k++) power_sums[k] = 0;

    // directed table; typed values list moment 4 down to the mean
    // after reset: three streams, four moments, zeros give all-zero averages
    dir_rows.push_back(sample_row(16'h0000));
    dir_rows.push_back(sample_row(16'h0000));
    dir_rows.push_back(typed_row(16'h0000, {16'h0000, 16'h0000, 16'h0000, 16'h0000}));
    // all -1.0: even powers are +1.0 exactly and their average saturates
    dir_rows.push_back(sample_row(16'h8000));
    dir_rows.push_back(sample_row(16'h8000));
    dir_rows.push_back(typed_row(16'h8000, {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}));
    // largest positive: each power loses one lsb to truncation
    dir_rows.push_back(sample_row(16'h7FFF));
    dir_rows.push_back(sample_row(16'h7FFF));
    dir_rows.push_back(typed_row(16'h7FFF, {16'h7FFC, 16'h7FFD, 16'h7FFE, 16'h7FFF}));
    // zero settings clamp up to three streams and one moment
    dir_rows.push_back(config_row(rma_pkg::CFG_NUM_STREAMS, 7'd0));
    dir_rows.push_back(config_row(rma_pkg::CFG_NUM_MOMENTS, 7'd0));
    dir_rows.push_back(sample_row(16'h5555));
    dir_rows.push_back(sample_row(16'hAAAA));
    dir_rows.push_back(sample_row(16'h0001));
    // too few streams and too many moments clamp to three and four
    dir_rows.push_back(config_row(rma_pkg::CFG_NUM_STREAMS, 7'd1));
    dir_rows.push_back(config_row(rma_pkg::CFG_NUM_MOMENTS, 7'd7));
    dir_rows.push_back(sample_row(16'hFFFF));
    dir_rows.push_back(sample_row(16'h0001));
    dir_rows.push_back(sample_row(16'h8000));
    // settings changed inside a position: more moments later, then as many streams
    // as already taken, so the next sample closes the position
    dir_rows.push_back(config_row(rma_pkg::CFG_NUM_STREAMS, 7'd5));
    dir_rows.push_back(config_row(rma_pkg::CFG_NUM_MOMENTS, 7'd1));
    dir_rows.push_back(sample_row(16'h0064));
    dir_rows.push_back(sample_row(16'h00C8));
    dir_rows.push_back(config_row(rma_pkg::CFG_NUM_MOMENTS, 7'd4));
    dir_rows.push_back(sample_row(16'h012C));
    dir_rows.push_back(config_row(rma_pkg::CFG_NUM_STREAMS, 7'd3));
    dir_rows.push_back(sample_row(16'h0190));
    // five -1.0 samples over three streams: averages beyond +-1.0 saturate both ways
    dir_rows.push_back(config_row(rma_pkg::CFG_NUM_STREAMS, 7'd5));
    dir_rows.push_back(sample_row(16'h8000));
    dir_rows.push_back(sample_row(16'h8000));
    dir_rows.push_back(sample_row(16'h8000));
    dir_rows.push_back(sample_row(16'h8000));
    dir_rows.push_back(config_row(rma_pkg::CFG_NUM_STREAMS, 7'd3));
    dir_rows.push_back(typed_row(16'h8000, {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}));
    // upper data bits of the moment count are dropped; spare indexes do nothing
    dir_rows.push_back(config_row(rma_pkg::CFG_NUM_MOMENTS, 7'b1111010));
    dir_rows.push_back(config_row(CFG_SPARE_2, 7'h7F));
    dir_rows.push_back(config_row(CFG_SPARE_3, 7'h55));
    dir_rows.push_back(sample_row(16'h1234));
    dir_rows.push_back(sample_row(16'hEDCB));
    dir_rows.push_back(sample_row(16'h4000));

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG)
        write_register(dir_rows[i].idx, dir_rows[i].val);
      else
        offer_sample(dir_rows[i].x, dir_rows[i].typed, dir_rows[i].want);
    end

    // random phases: one full-width position near the sum limit, then the minimum
    // stream count, then small counts with random, often out-of-range settings
    for (int ph = 0; ph < PHASES; ph++) begin
      steady = (ph % 4 == 2);
      if (ph == 0) begin
        nstr = 127;
        nmom = 4;
        positions = 1;
      end else if (ph == 1) begin
        nstr = rma_pkg::NUM_STREAMS_MIN;
        nmom = 1;
        positions = 2;
      end else begin
        nstr = $urandom_range(0, 9);
        nmom = $urandom_range(0, 7);
        positions = (ph == 3) ? 3 : $urandom_range(1, 2);
      end
      write_register(rma_pkg::CFG_NUM_STREAMS, rma_pkg::CFG_DATA_W'(nstr));
      write_register(rma_pkg::CFG_NUM_MOMENTS, rma_pkg::CFG_DATA_W'(nmom));
      // long hold-off on the result side while samples keep coming
      if (ph == 3) hold_ask = 1'b1;
      per = (nstr < rma_pkg::NUM_STREAMS_MIN) ? rma_pkg::NUM_STREAMS_MIN :
            (nstr > STREAMS) ? STREAMS : nstr;
      for (int pos = 0; pos < positions; pos++)
        for (int i = 0; i < per; i++)
          offer_sample(draw_sample(ph == 0), 1'b0, '0);
    end
    steady = 1'b0;
    s_tvalid <= 1'b0;

    while (moment_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (moment_q.size() != 0)
      note_error($sformatf("%0d results never arrived", moment_q.size()));

    $display("covered %0d samples and %0d register writes over directed and random phases",
             samples_sent, writes_done);
    $display("%0d moment results checked, %0d mismatches", results_seen, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/rma_pkg.sv
design/rma_ctrl.sv
design/rma_dp.sv
design/raw_moment_accumulator.sv
bench/raw_moment_accumulator_test.sv
